>>> design/fctp_pkg.sv
// Package for the FLAC comment tag parser: phase encoding, result kinds,
// magic and tag name tables. No dependencies.
package fctp_pkg;

  typedef enum logic [10:0] {
    PH_MAGIC  = 11'b000_0000_0001,
    PH_HDR    = 11'b000_0000_0010,
    PH_SKIP   = 11'b000_0000_0100,
    PH_VLEN   = 11'b000_0000_1000,
    PH_VENDOR = 11'b000_0001_0000,
    PH_COUNT  = 11'b000_0010_0000,
    PH_CLEN   = 11'b000_0100_0000,
    PH_KEY    = 11'b000_1000_0000,
    PH_VEMIT  = 11'b001_0000_0000,
    PH_VSKIP  = 11'b010_0000_0000,
    PH_DONE   = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    K_BYTE      = 3'd0,
    K_EMPTY     = 3'd1,
    K_SUCCESS   = 3'd2,
    K_NOCOMMENT = 3'd3,
    K_NOTFLAC   = 3'd4,
    K_TRUNC     = 3'd5
  } kind_t;

  localparam int NTAGS = 7;
  localparam int NAME_CHARS = 11;
  localparam logic [6:0] COMMENT_TYPE = 7'd4;
  localparam logic [7:0] EQUALS_CHAR = 8'h3D;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [2:0] tag;
    logic [7:0] byte_val;
    logic       lastv;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    magic_byte = 8'h66;
      2'd1:    magic_byte = 8'h4c;
      2'd2:    magic_byte = 8'h61;
      default: magic_byte = 8'h43;
    endcase
  endfunction

  function automatic logic [3:0] tag_len(input logic [2:0] t);
    case (t)
      3'd0:    tag_len = 4'd5;
      3'd1:    tag_len = 4'd6;
      3'd2:    tag_len = 4'd5;
      3'd3:    tag_len = 4'd4;
      3'd4:    tag_len = 4'd7;
      3'd5:    tag_len = 4'd11;
      default: tag_len = 4'd5;
    endcase
  endfunction

  // Character of tag t at position p; zero beyond the name.
  function automatic logic [7:0] tag_char(input logic [2:0] t, input logic [3:0] p);
    logic [87:0] s;
    s = '0;
    case (t)
      3'd0:    s = {"title", 48'd0};
      3'd1:    s = {"artist", 40'd0};
      3'd2:    s = {"album", 48'd0};
      3'd3:    s = {"date", 56'd0};
      3'd4:    s = {"comment", 32'd0};
      3'd5:    s = "tracknumber";
      default: s = {"genre", 48'd0};
    endcase
    if (p < 4'(NAME_CHARS)) tag_char = s[87 - 8 * int'(p) -: 8];
    else tag_char = 8'd0;
  endfunction

endpackage

>>> design/fctp_key_match.sv
// Key matcher: folds one key character and clears match bits of names that
// differ; also resolves the matched tag at '='. Uses fctp_pkg.
module fctp_key_match import fctp_pkg::*; #(
  parameter int MAX_KEY_CHARS = 12
) (
  input  logic [7:0] chr,
  input  logic [3:0] key_pos,
  input  logic [6:0] match_in,
  output logic [6:0] match_out,
  output logic [3:0] key_pos_out,
  output logic       matched,
  output logic [2:0] matched_tag
);

  logic [7:0] folded;

  always_comb begin
    folded = (chr >= 8'h41 && chr <= 8'h5A) ? chr + 8'd32 : chr;
    match_out   = match_in;
    key_pos_out = key_pos;
    if (5'(key_pos) < 5'(MAX_KEY_CHARS)) begin
      for (int i = 0; i < NTAGS; i++) begin
        if (key_pos >= tag_len(3'(i)) || tag_char(3'(i), key_pos) != folded)
          match_out[i] = 1'b0;
      end
      key_pos_out = key_pos + 4'd1;
    end
    matched     = 1'b0;
    matched_tag = 3'd0;
    for (int i = NTAGS - 1; i >= 0; i--) begin
      if (match_in[i] && key_pos == tag_len(3'(i))) begin
        matched     = 1'b1;
        matched_tag = 3'(i);
      end
    end
  end

endmodule

>>> design/flac_comment_tag_parser.sv
// FLAC comment tag parser top level: byte-wide parse state, result skid.
// Depends on fctp_pkg and fctp_key_match.
//
// Usage: one file byte per input word on in_* (valid/ready); in_start_of_stream
// restarts parsing at the magic check, in_end_of_stream marks the last byte.
// Each byte yields zero, one or two result words on out_* (valid/ready);
// out_last_of_run flags the final word for a byte. The user must write the
// limit register through cfg_valid/cfg_ready/cfg_value_byte_limit only while
// idle, which the block itself does not enforce. A byte's results are
// registered into the result buffer as the byte is accepted. Input runs one
// byte per cycle while the receiver takes every result; a byte with two
// results fills the two-word buffer, and the input waits until one word drains.
// Reset (rst_n low, synchronous) sets the limit to 255, clears the parse state
// to the magic check and empties the result buffer.
// When the receiver stalls, results hold and in_ready drops once the buffer
// cannot take a full run of two words.
module flac_comment_tag_parser import fctp_pkg::*; #(
  parameter int MAX_KEY_CHARS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_stream,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_tag_id,
  output logic [7:0]  out_value_byte,
  output logic        out_last_of_value,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_value_byte_limit
);

  logic [15:0] limit_r;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  fidx_r, fidx_nxt;
  logic [23:0] blk_r, blk_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] ccnt_r, ccnt_nxt;
  logic [31:0] cbytes_r, cbytes_nxt;
  logic [3:0]  kpos_r, kpos_nxt;
  logic [6:0]  mbits_r, mbits_nxt;
  logic [15:0] emit_r, emit_nxt;
  logic [2:0]  tag_r, tag_nxt;

  // two-entry result buffer
  result_t     q_r [2];
  result_t     q_nxt [2];
  logic        qlast_r [2];
  logic        qlast_nxt [2];
  logic [1:0]  qcnt_r, qcnt_nxt;
  logic [1:0]  qc;

  result_t     r0, r1;
  logic        take;

  phase_t      ph;
  logic [1:0]  fi;
  logic [23:0] bl;
  logic [31:0] wa, ca, cb, wle, cb_dec;
  logic [3:0]  kp;
  logic [6:0]  mb;
  logic [15:0] ec, lim;
  logic [2:0]  tg;
  logic [31:0] hdr;
  logic        word_done;

  logic [6:0]  km_match;
  logic [3:0]  km_pos;
  logic        km_hit;
  logic [2:0]  km_tag;

  fctp_key_match #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_km (
    .chr        (in_data_byte),
    .key_pos    (kp),
    .match_in   (mb),
    .match_out  (km_match),
    .key_pos_out(km_pos),
    .matched    (km_hit),
    .matched_tag(km_tag)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (qcnt_r == 2'd0) || (qcnt_r == 2'd1 && out_ready);
  assign take      = in_valid && in_ready;

  always_comb begin
    ph = phase_r; fi = fidx_r; bl = blk_r; wa = word_r; ca = ccnt_r;
    cb = cbytes_r; kp = kpos_r; mb = mbits_r; ec = emit_r; tg = tag_r;
    if (in_start_of_stream) begin
      ph = PH_MAGIC; fi = '0; bl = '0; wa = '0; ca = '0; cb = '0;
      kp = '0; mb = '1; ec = '0; tg = '0;
    end
    phase_nxt = ph; fidx_nxt = fi; blk_nxt = bl; word_nxt = wa; ccnt_nxt = ca;
    cbytes_nxt = cb; kpos_nxt = kp; mbits_nxt = mb; emit_nxt = ec; tag_nxt = tg;
    r0 = '0; r1 = '0;
    lim = (limit_r == 16'd0) ? 16'd1 : limit_r;
    cb_dec = cb - 32'd1;
    hdr = (fi == 2'd0) ? 32'd0 : wa;
    hdr[31 - 8 * int'(fi) -: 8] = in_data_byte;
    wle = (fi == 2'd0) ? 32'd0 : wa;
    wle[8 * int'(fi) +: 8] = in_data_byte;
    word_done = (fi == 2'd3);

    case (ph)
      PH_MAGIC: begin
        if (in_data_byte != magic_byte(fi)) begin
          r0.vld = 1'b1; r0.kind = K_NOTFLAC; phase_nxt = PH_DONE;
        end else if (fi == 2'd3) begin
          phase_nxt = PH_HDR; fidx_nxt = '0;
        end else begin
          fidx_nxt = fi + 2'd1;
        end
      end
      PH_HDR: begin
        word_nxt = hdr;
        fidx_nxt = fi + 2'd1;
        if (word_done) begin
          blk_nxt = hdr[23:0];
          if (hdr[30:24] == COMMENT_TYPE) begin
            phase_nxt = PH_VLEN; fidx_nxt = '0;
          end else if (hdr[31]) begin
            r0.vld = 1'b1; r0.kind = K_NOCOMMENT; phase_nxt = PH_DONE;
          end else if (hdr[23:0] != 24'd0) begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        blk_nxt = bl - 24'd1;
        if (blk_nxt == 24'd0) begin
          phase_nxt = PH_HDR; fidx_nxt = '0;
        end
      end
      PH_VLEN: begin
        word_nxt = wle; fidx_nxt = fi + 2'd1;
        if (word_done) begin
          cbytes_nxt = wle;
          phase_nxt = (wle != 32'd0) ? PH_VENDOR : PH_COUNT;
        end
      end
      PH_VENDOR: begin
        cbytes_nxt = cb_dec;
        if (cb_dec == 32'd0) begin
          phase_nxt = PH_COUNT; fidx_nxt = '0;
        end
      end
      PH_COUNT: begin
        word_nxt = wle; fidx_nxt = fi + 2'd1;
        if (word_done) begin
          ccnt_nxt = wle;
          if (wle == 32'd0) begin
            r0.vld = 1'b1; r0.kind = K_SUCCESS; phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_CLEN; fidx_nxt = '0;
          end
        end
      end
      default: begin
        // comment phases: CLEN, KEY, VEMIT, VSKIP share the end-of-comment step
        if (ph == PH_DONE) begin
          phase_nxt = PH_DONE;
        end else begin
          logic ended;
          ended = 1'b0;
          if (ph == PH_CLEN) begin
            word_nxt = wle; fidx_nxt = fi + 2'd1;
            if (word_done) begin
              cbytes_nxt = wle; kpos_nxt = '0; mbits_nxt = '1;
              if (wle == 32'd0) ended = 1'b1;
              else phase_nxt = PH_KEY;
            end
          end else if (ph == PH_KEY) begin
            cbytes_nxt = cb_dec;
            if (in_data_byte == EQUALS_CHAR) begin
              emit_nxt = '0;
              if (km_hit) tag_nxt = km_tag;
              if (cb_dec == 32'd0) begin
                if (km_hit) begin
                  r0.vld = 1'b1; r0.kind = K_EMPTY; r0.tag = km_tag;
                end
                ended = 1'b1;
              end else begin
                phase_nxt = km_hit ? PH_VEMIT : PH_VSKIP;
              end
            end else begin
              mbits_nxt = km_match; kpos_nxt = km_pos;
              if (cb_dec == 32'd0) ended = 1'b1;
            end
          end else if (ph == PH_VEMIT) begin
            cbytes_nxt = cb_dec;
            if (ec < lim) begin
              emit_nxt = ec + 16'd1;
              r0.vld = 1'b1; r0.kind = K_BYTE; r0.tag = tg;
              r0.byte_val = in_data_byte;
              r0.lastv = (cb_dec == 32'd0) || (emit_nxt == lim);
            end
            if (cb_dec == 32'd0) ended = 1'b1;
          end else if (ph == PH_VSKIP) begin
            cbytes_nxt = cb_dec;
            if (cb_dec == 32'd0) ended = 1'b1;
          end
          if (ended) begin
            ccnt_nxt = ca - 32'd1;
            if (ccnt_nxt == 32'd0) begin
              // success goes after any value result of this byte
              if (r0.vld) begin
                r1.vld = 1'b1; r1.kind = K_SUCCESS;
              end else begin
                r0.vld = 1'b1; r0.kind = K_SUCCESS;
              end
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_CLEN; fidx_nxt = '0;
            end
          end
        end
      end
    endcase

    if (in_end_of_stream && phase_nxt != PH_DONE) begin
      if (!r0.vld) begin
        r0.vld = 1'b1; r0.kind = K_TRUNC;
      end else if (!r1.vld) begin
        r1.vld = 1'b1; r1.kind = K_TRUNC;
      end
      phase_nxt = PH_DONE;
    end
  end

  // drain one word, then append this byte's run
  always_comb begin
    q_nxt[0] = q_r[0]; q_nxt[1] = q_r[1];
    qlast_nxt[0] = qlast_r[0]; qlast_nxt[1] = qlast_r[1];
    qc = qcnt_r;
    if (out_valid && out_ready) begin
      q_nxt[0] = q_r[1]; qlast_nxt[0] = qlast_r[1];
      qc = qc - 2'd1;
    end
    if (take && r0.vld) begin
      q_nxt[qc[0]] = r0; qlast_nxt[qc[0]] = !r1.vld;
      if (r1.vld) begin
        q_nxt[1] = r1; qlast_nxt[1] = 1'b1;
        qc = 2'd2;
      end else begin
        qc = qc + 2'd1;
      end
    end
    qcnt_nxt = qc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'd255;
      phase_r <= PH_MAGIC; fidx_r <= '0; blk_r <= '0; word_r <= '0;
      ccnt_r <= '0; cbytes_r <= '0; kpos_r <= '0; mbits_r <= '1;
      emit_r <= '0; tag_r <= '0;
      qcnt_r <= '0;
    end else begin
      if (cfg_valid) limit_r <= cfg_value_byte_limit;
      if (take) begin
        phase_r <= phase_nxt; fidx_r <= fidx_nxt; blk_r <= blk_nxt;
        word_r <= word_nxt; ccnt_r <= ccnt_nxt; cbytes_r <= cbytes_nxt;
        kpos_r <= kpos_nxt; mbits_r <= mbits_nxt; emit_r <= emit_nxt;
        tag_r <= tag_nxt;
      end
      q_r[0] <= q_nxt[0]; q_r[1] <= q_nxt[1];
      qlast_r[0] <= qlast_nxt[0]; qlast_r[1] <= qlast_nxt[1];
      qcnt_r <= qcnt_nxt;
    end
  end

  assign out_valid         = (qcnt_r != 2'd0);
  assign out_kind          = q_r[0].kind;
  assign out_tag_id        = q_r[0].tag;
  assign out_value_byte    = q_r[0].byte_val;
  assign out_last_of_value = q_r[0].lastv;
  assign out_last_of_run   = qlast_r[0];

endmodule

>>> tb/tb_flac_comment_tag_parser.sv
// Testbench for the FLAC comment tag parser: drives file bytes, predicts the
// tag/outcome words in a behavioral parser model and checks them in order.
// Depends on fctp_pkg and the flac_comment_tag_parser RTL.
module tb_flac_comment_tag_parser;
  import fctp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    S_MAGIC, S_HDR, S_SKIP, S_VLEN, S_VENDOR, S_COUNT, S_CLEN, S_KEY, S_VEMIT,
    S_VSKIP, S_DONE
  } pstate_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] tag;
    logic [7:0] vbyte;
    logic       lastv;
    logic       lastr;
  } tag_word_t;

  localparam int KEY_CHARS = 12;
  localparam logic [7:0] MAGIC0 = 8'h66, MAGIC1 = 8'h4c, MAGIC2 = 8'h61, MAGIC3 = 8'h43;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, in_sos = 0, in_eos = 0;
  logic [7:0] in_byte = 0;
  logic out_valid, out_ready = 0, out_lastv, out_lastr;
  logic [2:0] out_kind, out_tag;
  logic [7:0] out_vbyte;
  logic cfg_valid = 0, cfg_ready;
  logic [15:0] cfg_limit = 0;

  flac_comment_tag_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_byte),
    .in_start_of_stream(in_sos), .in_end_of_stream(in_eos),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_tag_id(out_tag), .out_value_byte(out_vbyte),
    .out_last_of_value(out_lastv), .out_last_of_run(out_lastr),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_value_byte_limit(cfg_limit)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // parser model state
  pstate_t    ph;
  int unsigned fidx, blk_left, word, cmts_left, cmt_left, key_pos, emitted, cur_tag;
  logic [6:0] match_bits;
  int unsigned byte_limit;
  tag_word_t  expected_words[$];
  tag_word_t  run_words[$];

  int errors = 0, words_seen = 0, bytes_sent = 0;
  int send_idle_pct = 0, recv_idle_pct = 0, hold_cycles = 0;

  string tag_names[7] = '{"title", "artist", "album", "date", "comment", "tracknumber",
                         "genre"};

  function automatic logic [7:0] magic_at(int i);
    case (i)
      0: return MAGIC0;
      1: return MAGIC1;
      2: return MAGIC2;
      default: return MAGIC3;
    endcase
  endfunction

  function void push_word(kind_t k, int t, int b, bit lv);
    tag_word_t w;
    if (run_words.size() >= 2) return;
    w.kind = k; w.tag = 3'(t); w.vbyte = 8'(b); w.lastv = lv; w.lastr = 0;
    run_words.push_back(w);
  endfunction

  function void parser_restart();
    ph = S_MAGIC; fidx = 0; blk_left = 0; word = 0; cmts_left = 0; cmt_left = 0;
    key_pos = 0; match_bits = '1; emitted = 0; cur_tag = 0;
  endfunction

  function bit gather_le(logic [7:0] b);
    int unsigned i;
    i = fidx & 3;
    if (i == 0) word = 0;
    word |= int'(b) << (8 * i);
    fidx = (i + 1) & 3;
    return i == 3;
  endfunction

  function void close_comment();
    cmts_left = cmts_left - 1;
    if (cmts_left == 0) begin
      push_word(K_SUCCESS, 0, 0, 0);
      ph = S_DONE;
    end else begin
      ph = S_CLEN; fidx = 0;
    end
  endfunction

  function void predict_byte(logic [7:0] b, bit sos, bit eos);
    int unsigned lim;
    logic [7:0] c;
    bit hit;
    run_words.delete();
    if (sos) parser_restart();
    case (ph)
      S_MAGIC: begin
        if (b != magic_at(fidx & 3)) begin
          push_word(K_NOTFLAC, 0, 0, 0); ph = S_DONE;
        end else if ((fidx & 3) == 3) begin
          ph = S_HDR; fidx = 0;
        end else fidx++;
      end
      S_HDR: begin
        if (fidx == 0) word = 0;
        word |= int'(b) << (8 * (3 - fidx));
        fidx = (fidx + 1) & 3;
        if (fidx == 0) begin
          blk_left = word & 24'hFFFFFF;
          if (((word >> 24) & 7'h7F) == 4) begin
            ph = S_VLEN; fidx = 0;
          end else if (word[31]) begin
            push_word(K_NOCOMMENT, 0, 0, 0); ph = S_DONE;
          end else if (blk_left != 0) ph = S_SKIP;
        end
      end
      S_SKIP: begin
        blk_left = (blk_left - 1) & 24'hFFFFFF;
        if (blk_left == 0) begin
          ph = S_HDR; fidx = 0;
        end
      end
      S_VLEN: if (gather_le(b)) begin
        cmt_left = word;
        ph = (cmt_left != 0) ? S_VENDOR : S_COUNT;
      end
      S_VENDOR: begin
        cmt_left--;
        if (cmt_left == 0) begin
          ph = S_COUNT; fidx = 0;
        end
      end
      S_COUNT: if (gather_le(b)) begin
        cmts_left = word;
        if (cmts_left == 0) begin
          push_word(K_SUCCESS, 0, 0, 0); ph = S_DONE;
        end else begin
          ph = S_CLEN; fidx = 0;
        end
      end
      S_CLEN: if (gather_le(b)) begin
        cmt_left = word; key_pos = 0; match_bits = '1;
        if (cmt_left == 0) close_comment();
        else ph = S_KEY;
      end
      S_KEY: begin
        cmt_left--;
        if (b == EQUALS_CHAR) begin
          hit = 0;
          for (int i = 0; i < 7; i++)
            if (!hit && match_bits[i] && key_pos == tag_names[i].len()) begin
              hit = 1; cur_tag = i;
            end
          emitted = 0;
          if (cmt_left == 0) begin
            if (hit) push_word(K_EMPTY, cur_tag, 0, 0);
            close_comment();
          end else ph = hit ? S_VEMIT : S_VSKIP;
        end else begin
          c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          if (key_pos < KEY_CHARS) begin
            for (int i = 0; i < 7; i++)
              if (key_pos >= tag_names[i].len() || tag_names[i][key_pos] != c)
                match_bits[i] = 0;
            key_pos++;
          end
          if (cmt_left == 0) close_comment();
        end
      end
      S_VEMIT: begin
        cmt_left--;
        lim = (byte_limit == 0) ? 1 : byte_limit;
        if (emitted < lim) begin
          emitted++;
          push_word(K_BYTE, cur_tag, b, (cmt_left == 0) || (emitted == lim));
        end
        if (cmt_left == 0) close_comment();
      end
      S_VSKIP: begin
        cmt_left--;
        if (cmt_left == 0) close_comment();
      end
      default: ph = S_DONE;
    endcase
    if (eos && ph != S_DONE) begin
      push_word(K_TRUNC, 0, 0, 0); ph = S_DONE;
    end
    if (run_words.size() > 0) run_words[run_words.size() - 1].lastr = 1;
    foreach (run_words[i]) expected_words.push_back(run_words[i]);
  endfunction

  // Send one byte; hold it until accepted.
  task automatic send_byte(logic [7:0] b, bit sos = 0, bit eos = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_byte <= b; in_sos <= sos; in_eos <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, sos, eos);
    bytes_sent++;
  endtask

  task automatic send_le32(int unsigned v);
    for (int i = 0; i < 4; i++) send_byte(8'(v >> (8 * i)));
  endtask

  task automatic send_header(bit last, logic [6:0] btype, logic [23:0] len);
    send_byte({last, btype});
    send_byte(len[23:16]); send_byte(len[15:8]); send_byte(len[7:0]);
  endtask

  task automatic send_magic();
    send_byte(MAGIC0, 1);
    send_byte(MAGIC1); send_byte(MAGIC2); send_byte(MAGIC3);
  endtask

  task automatic send_comment(string s);
    send_le32(s.len());
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1; cfg_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    byte_limit = v;
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 0; hold_cycles <= hold_cycles - 1;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    tag_word_t w;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind=%0d tag=%0d byte=%h",
                 $realtime, out_kind, out_tag, out_vbyte);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_kind != w.kind || out_tag != w.tag || out_vbyte != w.vbyte ||
            out_lastv != w.lastv || out_lastr != w.lastr) begin
          $display("%0t: mismatch expected k=%0d t=%0d b=%h lv=%0b lr=%0b", $realtime,
                   w.kind, w.tag, w.vbyte, w.lastv, w.lastr);
          $display("%0t:          actual   k=%0d t=%0d b=%h lv=%0b lr=%0b", $realtime,
                   out_kind, out_tag, out_vbyte, out_lastv, out_lastr);
          errors++;
        end
      end
    end
  end

  // Random key, mostly a known tag in random case.
  function automatic string pick_key();
    string k;
    int r;
    r = $urandom_range(9);
    if (r < 7) k = tag_names[r];
    else if (r == 7) k = "tracknumberxyz";
    else k = "foo";
    foreach (k[i]) if ($urandom_range(1) && k[i] >= "a" && k[i] <= "z") k[i] = k[i] - 32;
    return k;
  endfunction

  task automatic send_random_file();
    int ncm, vlen, r;
    string k;
    send_magic();
    if ($urandom_range(3) == 0) begin
      r = $urandom_range(5);
      send_header(0, 7'($urandom_range(0, 3)), 24'(r));
      repeat (r) send_byte(8'($urandom));
    end
    send_header($urandom_range(1), 7'd4, 24'($urandom));
    vlen = $urandom_range(3);
    send_le32(vlen);
    repeat (vlen) send_byte(8'($urandom));
    ncm = $urandom_range(1, 4);
    send_le32(ncm);
    for (int c = 0; c < ncm; c++) begin
      k = pick_key();
      vlen = $urandom_range(0, 12);
      if ($urandom_range(15) == 0) begin
        send_le32(k.len());
        foreach (k[i]) send_byte(k[i]);
      end else begin
        send_le32(k.len() + 1 + vlen);
        foreach (k[i]) send_byte(k[i]);
        send_byte(EQUALS_CHAR);
        repeat (vlen) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1);                      // not FLAC
    send_byte(8'hFF, 0, 1);                   // ignored after outcome
    send_magic(); send_header(1, 7'd0, 24'd0); // last non-comment block
    send_magic(); send_header(0, 7'h7F, 24'd2); send_byte(8'h00); send_byte(8'hFF);
    send_header(0, 7'd4, 24'hFFFFFF); send_le32(0); send_le32(0); // count zero
    send_magic(); send_header(0, 7'd4, 24'd0); send_le32(1); send_byte(8'h5A);
    send_le32(8);
    send_comment(""); send_comment("TiTlE=ab"); send_comment("DATE=");
    send_comment("genrex"); send_comment("Zz=q");
    send_comment("TRACKNUMBERXYZ=1"); send_comment("tracknumber=7");
    send_comment("artist=hello");
    send_magic(); send_byte(8'h84, 0, 1);     // truncated
  endtask

  task automatic test_random(int n_bytes);
    int goal;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      if ($urandom_range(9) == 0) send_byte(8'($urandom), $urandom_range(1), $urandom_range(1));
      else send_random_file();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    send_magic(); send_header(1, 7'd4, 24'd1); send_le32(0); send_le32(1);
    send_comment("album=abcdefghijklmnopqrstuvwxyz");
    wait_drained();
  endtask

  initial begin
    byte_limit = 255;
    parser_restart();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    write_limit(16'd0); test_directed();
    write_limit(16'd3); send_idle_pct = 28; recv_idle_pct = 87; test_random(250);
    write_limit(16'hFFFF); send_idle_pct = 87; recv_idle_pct = 28; test_random(250);
    write_limit(16'd1); send_idle_pct = 0; recv_idle_pct = 0; test_random(250);
    test_backpressure();
    write_limit(16'd5); test_random(50);
    wait_drained();
    $display("Sent %0d file bytes, checked %0d result words across limits 0,1,3,5,255,65535",
             bytes_sent, words_seen);
    if (errors == 0 && expected_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout waiting for results");
    $display("== FAIL ==");
    $finish;
  end

endmodule
